// ----- src/ges_pkg.sv -----
// ----------------------------------------------------------------------------
// ges_pkg
// Shared types and fixed field widths for the Gaussian elimination solver.
// ----------------------------------------------------------------------------
package ges_pkg;

	// Stream and register field widths
	localparam int COEF_W      = 32;
	localparam int OUT_VAL_W   = 32;
	localparam int OUT_IDX_W   = 4;
	localparam int ORDER_CFG_W = 5;
	localparam int M_TDATA_W   = 40;

	// Datapath commands issued by the controller
	typedef struct packed {
		logic mrd;         // matrix read
		logic mwe;         // matrix write
		logic wsel_coef;   // matrix write data: incoming coefficient
		logic srd;         // solution read
		logic swe;         // solution write (quotient)
		logic ld_piv;      // pivot <= matrix read data
		logic ld_acc;      // accumulator <= matrix read data
		logic ld_opa;      // operand a <= matrix read data
		logic ld_opb_div;  // operand b <= quotient
		logic ld_opb_sol;  // operand b <= solution read data
		logic mul_start;
		logic div_start;
		logic acc_sub;     // accumulator <= accumulator - product
		logic ld_out;      // output value <= solution read data
		logic out_zero;    // output value <= 0
	} ges_cmd_t;

	// Datapath status returned to the controller
	typedef struct packed {
		logic mrd_zero;
		logic mul_done;
		logic div_done;
	} ges_sts_t;

endpackage

// ----- src/ges_ram.sv -----
// ----------------------------------------------------------------------------
// ges_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ges_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/ges_mul.sv -----
// ----------------------------------------------------------------------------
// ges_mul
// Iterative Q16.16 multiplier, 16 multiplier bits per cycle, saturating.
// ----------------------------------------------------------------------------
module ges_mul #(
	parameter int W = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [W-1:0] a,
	input  logic signed [W-1:0] b,
	output logic                done,
	output logic signed [W-1:0] res
);

	localparam int NCH = (W + 15) / 16;
	localparam int YW  = NCH * 16;
	localparam int PW  = W + YW;
	localparam int MW  = PW - 16;
	localparam int CW  = $clog2(NCH + 1);

	logic [W-1:0]  x_q;
	logic [YW-1:0] y_q;
	logic [PW-1:0] acc_q;
	logic          neg_q;
	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [W+15:0] pp;

	function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
		return v[W-1] ? W'(-v) : W'(v);
	endfunction

	function automatic logic [W-1:0] sat_mag(input logic neg, input logic [MW-1:0] m);
		logic [MW-1:0] lim;
		logic [W-1:0]  mm;
		lim = MW'({1'b0, {(W-1){1'b1}}}) + MW'(neg);
		mm  = (m > lim) ? lim[W-1:0] : m[W-1:0];
		return neg ? W'(-mm) : mm;
	endfunction

	assign pp = x_q * y_q[YW-1 -: 16];

	// Shift-add over the multiplier chunks, then saturate once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				x_q    <= mag(a);
				y_q    <= YW'(mag(b));
				neg_q  <= a[W-1] ^ b[W-1];
				acc_q  <= '0;
				cnt_q  <= CW'(NCH);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (cnt_q != '0) begin
					acc_q <= (acc_q << 16) + PW'(pp);
					y_q   <= y_q << 16;
					cnt_q <= cnt_q - 1'b1;
				end else begin
					res    <= sat_mag(neg_q, acc_q[PW-1:16]);
					done   <= 1'b1;
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

// ----- src/ges_div.sv -----
// ----------------------------------------------------------------------------
// ges_div
// Restoring Q16.16 divider, one quotient bit per cycle, truncating, saturating.
// ----------------------------------------------------------------------------
module ges_div #(
	parameter int W = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [W-1:0] num,
	input  logic signed [W-1:0] den,
	output logic                done,
	output logic signed [W-1:0] res
);

	localparam int QW = W + 16;
	localparam int CW = $clog2(QW + 1);

	logic [QW-1:0] dvd_q;
	logic [QW-1:0] q_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  d_q;
	logic          neg_q;
	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [W:0]    trial;
	logic          ge;

	function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
		return v[W-1] ? W'(-v) : W'(v);
	endfunction

	function automatic logic [W-1:0] sat_mag(input logic neg, input logic [QW-1:0] m);
		logic [QW-1:0] lim;
		logic [W-1:0]  mm;
		lim = QW'({1'b0, {(W-1){1'b1}}}) + QW'(neg);
		mm  = (m > lim) ? lim[W-1:0] : m[W-1:0];
		return neg ? W'(-mm) : mm;
	endfunction

	assign trial = {rem_q, dvd_q[QW-1]};
	assign ge    = trial >= {1'b0, d_q};

	// Shift in one dividend bit per cycle, then saturate the quotient
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				dvd_q  <= {mag(num), 16'b0};
				d_q    <= mag(den);
				rem_q  <= '0;
				q_q    <= '0;
				neg_q  <= num[W-1] ^ den[W-1];
				cnt_q  <= CW'(QW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (cnt_q != '0) begin
					rem_q <= ge ? W'(trial - {1'b0, d_q}) : W'(trial);
					q_q   <= {q_q[QW-2:0], ge};
					dvd_q <= dvd_q << 1;
					cnt_q <= cnt_q - 1'b1;
				end else begin
					res    <= sat_mag(neg_q, q_q);
					done   <= 1'b1;
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

// ----- src/ges_datapath.sv -----
// ----------------------------------------------------------------------------
// ges_datapath
// Matrix and solution stores, working registers, multiplier and divider.
// ----------------------------------------------------------------------------
module ges_datapath
	import ges_pkg::*;
#(
	parameter int VALUE_WIDTH = 32,
	parameter int MAX_ORDER   = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ges_cmd_t              cmd,
	output ges_sts_t              sts,
	input  logic [$clog2(MAX_ORDER*(MAX_ORDER+1))-1:0] mraddr,
	input  logic [$clog2(MAX_ORDER*(MAX_ORDER+1))-1:0] mwaddr,
	input  logic [(MAX_ORDER > 1 ? $clog2(MAX_ORDER) : 1)-1:0] sraddr,
	input  logic [(MAX_ORDER > 1 ? $clog2(MAX_ORDER) : 1)-1:0] swaddr,
	input  logic signed [COEF_W-1:0]    coef,
	output logic signed [OUT_VAL_W-1:0] out_value
);

	localparam int W     = VALUE_WIDTH;
	localparam int MDEP  = MAX_ORDER * (MAX_ORDER + 1);
	localparam int EW    = (W > COEF_W ? W : COEF_W) + 1;
	localparam logic signed [EW-1:0] VMAX = (EW'(1) <<< (W - 1)) - EW'(1);
	localparam logic signed [EW-1:0] VMIN = ~VMAX;
	localparam logic signed [EW-1:0] OMAX = EW'({1'b0, {(OUT_VAL_W-1){1'b1}}});
	localparam logic signed [EW-1:0] OMIN = ~OMAX;
	localparam logic signed [W:0]    SMAX = (W+1)'({1'b0, {(W-1){1'b1}}});
	localparam logic signed [W:0]    SMIN = ~SMAX;

	logic signed [W-1:0]  m_rdata;
	logic signed [W-1:0]  s_rdata;
	logic signed [W-1:0]  m_wdata;
	logic signed [EW-1:0] coef_ext;
	logic signed [EW-1:0] srd_ext;
	logic signed [W-1:0]  coef_sat;
	logic signed [W:0]    diff;
	logic signed [W-1:0]  diff_sat;
	logic signed [W-1:0]  piv_q;
	logic signed [W-1:0]  acc_q;
	logic signed [W-1:0]  opa_q;
	logic signed [W-1:0]  opb_q;
	logic signed [W-1:0]  mul_res;
	logic signed [W-1:0]  div_res;
	logic                 mul_done;
	logic                 div_done;

	// Clamp incoming coefficient to the working width
	assign coef_ext = EW'(coef);
	assign coef_sat = (coef_ext > VMAX) ? VMAX[W-1:0] :
	                  (coef_ext < VMIN) ? VMIN[W-1:0] : coef_ext[W-1:0];

	// Saturating subtract of the product from the accumulator
	assign diff     = (W+1)'(acc_q) - (W+1)'(mul_res);
	assign diff_sat = (diff > SMAX) ? SMAX[W-1:0] :
	                  (diff < SMIN) ? SMIN[W-1:0] : diff[W-1:0];

	assign m_wdata = cmd.wsel_coef ? coef_sat : acc_q;

	ges_ram #(.WIDTH(W), .DEPTH(MDEP)) u_mat (
		.clk   (clk),
		.we    (cmd.mwe),
		.waddr (mwaddr),
		.wdata (m_wdata),
		.re    (cmd.mrd),
		.raddr (mraddr),
		.rdata (m_rdata)
	);

	ges_ram #(.WIDTH(W), .DEPTH(MAX_ORDER)) u_sol (
		.clk   (clk),
		.we    (cmd.swe),
		.waddr (swaddr),
		.wdata (div_res),
		.re    (cmd.srd),
		.raddr (sraddr),
		.rdata (s_rdata)
	);

	ges_mul #(.W(W)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (opa_q),
		.b      (opb_q),
		.done   (mul_done),
		.res    (mul_res)
	);

	ges_div #(.W(W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (acc_q),
		.den    (piv_q),
		.done   (div_done),
		.res    (div_res)
	);

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.ld_piv) begin
			piv_q <= m_rdata;
		end
		if (cmd.ld_acc) begin
			acc_q <= m_rdata;
		end else if (cmd.acc_sub) begin
			acc_q <= diff_sat;
		end
		if (cmd.ld_opa) begin
			opa_q <= m_rdata;
		end
		if (cmd.ld_opb_div) begin
			opb_q <= div_res;
		end else if (cmd.ld_opb_sol) begin
			opb_q <= s_rdata;
		end
	end

	// Output value, narrowed to 32 bits
	assign srd_ext = EW'(s_rdata);
	always_ff @(posedge clk) begin
		if (cmd.out_zero) begin
			out_value <= '0;
		end else if (cmd.ld_out) begin
			out_value <= (srd_ext > OMAX) ? OMAX[OUT_VAL_W-1:0] :
			             (srd_ext < OMIN) ? OMIN[OUT_VAL_W-1:0] : srd_ext[OUT_VAL_W-1:0];
		end
	end

	assign sts.mrd_zero = (m_rdata == '0);
	assign sts.mul_done = mul_done;
	assign sts.div_done = div_done;

endmodule

// ----- src/ges_ctrl.sv -----
// ----------------------------------------------------------------------------
// ges_ctrl
// Sequencer for loading, forward elimination, back substitution and output.
// ----------------------------------------------------------------------------
module ges_ctrl
	import ges_pkg::*;
#(
	parameter int MAX_ORDER = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [ORDER_CFG_W-1:0] cfg_wr_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [OUT_IDX_W-1:0]  out_index,
	output logic                  out_last,
	output logic                  out_singular,
	output ges_cmd_t              cmd,
	input  ges_sts_t              sts,
	output logic [$clog2(MAX_ORDER*(MAX_ORDER+1))-1:0] mraddr,
	output logic [$clog2(MAX_ORDER*(MAX_ORDER+1))-1:0] mwaddr,
	output logic [(MAX_ORDER > 1 ? $clog2(MAX_ORDER) : 1)-1:0] sraddr,
	output logic [(MAX_ORDER > 1 ? $clog2(MAX_ORDER) : 1)-1:0] swaddr
);

	localparam int ADDR_W = $clog2(MAX_ORDER * (MAX_ORDER + 1));
	localparam int ORD_W  = $clog2(MAX_ORDER + 1);
	localparam int SIDX_W = MAX_ORDER > 1 ? $clog2(MAX_ORDER) : 1;

	typedef enum logic [4:0] {
		LOAD, E_PIV_RD, E_PIV_CHK, E_RAT_RD, E_RAT_LD, E_RAT_DIV, E_RAT_WAIT,
		E_K_RDA, E_K_RDB, E_K_LD, E_K_MUL, E_K_WR, F_RD, F_CHK,
		B_X_RD, B_X_LD, B_J_RDA, B_J_LD, B_J_GO, B_J_WAIT,
		B_D_RD, B_D_LD, B_D_GO, B_D_WAIT, O_RD, O_LD, O_WAIT, SING
	} state_t;

	state_t            state_q;
	logic [ORD_W-1:0]  n_q;
	logic [ADDR_W-1:0] stride_q;
	logic [ORD_W-1:0]  i_q;
	logic [ORD_W-1:0]  j_q;
	logic [ORD_W-1:0]  k_q;
	logic [ADDR_W-1:0] base_i_q;
	logic [ADDR_W-1:0] base_j_q;
	logic [ADDR_W-1:0] ld_cnt_q;
	logic [ORD_W-1:0]  n_new;
	logic              in_xfer;

	// Effective order from a register write
	always_comb begin
		if (cfg_wr_data == '0) begin
			n_new = ORD_W'(1);
		end else if (int'(cfg_wr_data) > MAX_ORDER) begin
			n_new = ORD_W'(MAX_ORDER);
		end else begin
			n_new = ORD_W'(cfg_wr_data);
		end
	end

	assign in_ready = (state_q == LOAD);
	assign in_xfer  = in_valid && in_ready;

	// Commands and addresses for the datapath
	always_comb begin
		cmd    = '0;
		mraddr = base_i_q + ADDR_W'(i_q);
		mwaddr = base_j_q + ADDR_W'(k_q);
		sraddr = i_q[SIDX_W-1:0];
		swaddr = i_q[SIDX_W-1:0];
		case (state_q)
			LOAD: begin
				cmd.mwe       = in_xfer;
				cmd.wsel_coef = 1'b1;
				mwaddr        = ld_cnt_q;
			end
			E_PIV_RD, F_RD, B_D_RD: cmd.mrd = 1'b1;
			E_PIV_CHK, B_D_LD:      cmd.ld_piv = 1'b1;
			E_RAT_RD: begin
				cmd.mrd = 1'b1;
				mraddr  = base_j_q + ADDR_W'(i_q);
			end
			E_RAT_LD, B_X_LD:       cmd.ld_acc = 1'b1;
			E_RAT_DIV, B_D_GO:      cmd.div_start = 1'b1;
			E_RAT_WAIT:             cmd.ld_opb_div = sts.div_done;
			E_K_RDA: begin
				cmd.mrd = 1'b1;
				mraddr  = base_i_q + ADDR_W'(k_q);
			end
			E_K_RDB: begin
				cmd.mrd    = 1'b1;
				cmd.ld_opa = 1'b1;
				mraddr     = base_j_q + ADDR_W'(k_q);
			end
			E_K_LD: begin
				cmd.ld_acc    = 1'b1;
				cmd.mul_start = 1'b1;
			end
			E_K_MUL, B_J_WAIT:      cmd.acc_sub = sts.mul_done;
			E_K_WR:                 cmd.mwe = 1'b1;
			B_X_RD: begin
				cmd.mrd = 1'b1;
				mraddr  = base_i_q + ADDR_W'(n_q);
			end
			B_J_RDA: begin
				cmd.mrd = 1'b1;
				cmd.srd = 1'b1;
				mraddr  = base_i_q + ADDR_W'(j_q);
				sraddr  = j_q[SIDX_W-1:0];
			end
			B_J_LD: begin
				cmd.ld_opa     = 1'b1;
				cmd.ld_opb_sol = 1'b1;
			end
			B_J_GO:                 cmd.mul_start = 1'b1;
			B_D_WAIT:               cmd.swe = sts.div_done;
			O_RD:                   cmd.srd = 1'b1;
			O_LD:                   cmd.ld_out = 1'b1;
			SING:                   cmd.out_zero = 1'b1;
			default: ;
		endcase
	end

	// State, counters and output flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= LOAD;
			n_q          <= ORD_W'(1);
			stride_q     <= ADDR_W'(2);
			i_q          <= '0;
			j_q          <= '0;
			k_q          <= '0;
			base_i_q     <= '0;
			base_j_q     <= '0;
			ld_cnt_q     <= '0;
			out_valid    <= 1'b0;
			out_index    <= '0;
			out_last     <= 1'b0;
			out_singular <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				n_q      <= n_new;
				stride_q <= ADDR_W'(n_new) + ADDR_W'(1);
				i_q      <= '0;
				k_q      <= '0;
				ld_cnt_q <= '0;
			end
			case (state_q)
				LOAD: begin
					if (in_xfer && !cfg_wr_en) begin
						if (k_q == n_q) begin
							k_q <= '0;
							if (i_q + ORD_W'(1) == n_q) begin
								i_q      <= '0;
								base_i_q <= '0;
								ld_cnt_q <= '0;
								state_q  <= (n_q == ORD_W'(1)) ? F_RD : E_PIV_RD;
							end else begin
								i_q      <= i_q + ORD_W'(1);
								ld_cnt_q <= ld_cnt_q + ADDR_W'(1);
							end
						end else begin
							k_q      <= k_q + ORD_W'(1);
							ld_cnt_q <= ld_cnt_q + ADDR_W'(1);
						end
					end
				end
				E_PIV_RD: state_q <= E_PIV_CHK;
				E_PIV_CHK: begin
					if (sts.mrd_zero) begin
						state_q <= SING;
					end else begin
						j_q      <= i_q + ORD_W'(1);
						base_j_q <= base_i_q + stride_q;
						state_q  <= E_RAT_RD;
					end
				end
				E_RAT_RD:  state_q <= E_RAT_LD;
				E_RAT_LD:  state_q <= E_RAT_DIV;
				E_RAT_DIV: state_q <= E_RAT_WAIT;
				E_RAT_WAIT: begin
					if (sts.div_done) begin
						k_q     <= '0;
						state_q <= E_K_RDA;
					end
				end
				E_K_RDA: state_q <= E_K_RDB;
				E_K_RDB: state_q <= E_K_LD;
				E_K_LD:  state_q <= E_K_MUL;
				E_K_MUL: begin
					if (sts.mul_done) begin
						state_q <= E_K_WR;
					end
				end
				E_K_WR: begin
					if (k_q != n_q) begin
						k_q     <= k_q + ORD_W'(1);
						state_q <= E_K_RDA;
					end else if (j_q + ORD_W'(1) != n_q) begin
						j_q      <= j_q + ORD_W'(1);
						base_j_q <= base_j_q + stride_q;
						state_q  <= E_RAT_RD;
					end else begin
						i_q      <= i_q + ORD_W'(1);
						base_i_q <= base_i_q + stride_q;
						state_q  <= (i_q + ORD_W'(2) == n_q) ? F_RD : E_PIV_RD;
					end
				end
				F_RD:  state_q <= F_CHK;
				F_CHK: state_q <= sts.mrd_zero ? SING : B_X_RD;
				B_X_RD: state_q <= B_X_LD;
				B_X_LD: begin
					j_q     <= i_q + ORD_W'(1);
					state_q <= (i_q + ORD_W'(1) == n_q) ? B_D_RD : B_J_RDA;
				end
				B_J_RDA: state_q <= B_J_LD;
				B_J_LD:  state_q <= B_J_GO;
				B_J_GO:  state_q <= B_J_WAIT;
				B_J_WAIT: begin
					if (sts.mul_done) begin
						if (j_q + ORD_W'(1) == n_q) begin
							state_q <= B_D_RD;
						end else begin
							j_q     <= j_q + ORD_W'(1);
							state_q <= B_J_RDA;
						end
					end
				end
				B_D_RD: state_q <= B_D_LD;
				B_D_LD: state_q <= B_D_GO;
				B_D_GO: state_q <= B_D_WAIT;
				B_D_WAIT: begin
					if (sts.div_done) begin
						if (i_q == '0) begin
							state_q <= O_RD;
						end else begin
							i_q      <= i_q - ORD_W'(1);
							base_i_q <= base_i_q - stride_q;
							state_q  <= B_X_RD;
						end
					end
				end
				O_RD: state_q <= O_LD;
				O_LD: begin
					out_valid    <= 1'b1;
					out_index    <= OUT_IDX_W'(i_q);
					out_last     <= (i_q + ORD_W'(1) == n_q);
					out_singular <= 1'b0;
					state_q      <= O_WAIT;
				end
				SING: begin
					out_valid    <= 1'b1;
					out_index    <= '0;
					out_last     <= 1'b1;
					out_singular <= 1'b1;
					state_q      <= O_WAIT;
				end
				O_WAIT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						if (out_last) begin
							i_q      <= '0;
							k_q      <= '0;
							ld_cnt_q <= '0;
							state_q  <= LOAD;
						end else begin
							i_q     <= i_q + ORD_W'(1);
							state_q <= O_RD;
						end
					end
				end
				default: state_q <= LOAD;
			endcase
		end
	end

endmodule

// ----- src/gauss_elimination_solver.sv -----
// Systems are taken one at a time: loading resumes only after the last result is
// accepted. The shared multiplier and the one matrix read port set the solve time.
// Reset: arst_n clears the sequencer and sets the order to 1; stores are not cleared.
// ----------------------------------------------------------------------------
// gauss_elimination_solver
// Linear system solver by forward elimination and back substitution, Q16.16.
// ----------------------------------------------------------------------------
module gauss_elimination_solver
	import ges_pkg::*;
#(
	parameter int MAX_ORDER   = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [ORDER_CFG_W-1:0] cfg_wr_data,    // system_order
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [COEF_W-1:0]      s_axis_tdata,   // [31:0] coefficient
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [M_TDATA_W-1:0]   m_axis_tdata,   // [31:0] solution_value, [35:32] unknown_index
	output logic                   m_axis_tlast,   // last_result
	output logic                   m_axis_tuser    // singular
);

	localparam int ADDR_W = $clog2(MAX_ORDER * (MAX_ORDER + 1));
	localparam int SIDX_W = MAX_ORDER > 1 ? $clog2(MAX_ORDER) : 1;

	ges_cmd_t                    cmd;
	ges_sts_t                    sts;
	logic [ADDR_W-1:0]           mraddr;
	logic [ADDR_W-1:0]           mwaddr;
	logic [SIDX_W-1:0]           sraddr;
	logic [SIDX_W-1:0]           swaddr;
	logic signed [OUT_VAL_W-1:0] out_value;
	logic [OUT_IDX_W-1:0]        out_index;

	ges_ctrl #(.MAX_ORDER(MAX_ORDER)) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.out_ready    (m_axis_tready),
		.out_valid    (m_axis_tvalid),
		.out_index    (out_index),
		.out_last     (m_axis_tlast),
		.out_singular (m_axis_tuser),
		.cmd          (cmd),
		.sts          (sts),
		.mraddr       (mraddr),
		.mwaddr       (mwaddr),
		.sraddr       (sraddr),
		.swaddr       (swaddr)
	);

	ges_datapath #(.VALUE_WIDTH(VALUE_WIDTH), .MAX_ORDER(MAX_ORDER)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.mraddr    (mraddr),
		.mwaddr    (mwaddr),
		.sraddr    (sraddr),
		.swaddr    (swaddr),
		.coef      (s_axis_tdata),
		.out_value (out_value)
	);

	// Pack result fields, zero padded to whole bytes
	assign m_axis_tdata = {{(M_TDATA_W-OUT_VAL_W-OUT_IDX_W){1'b0}}, out_index, out_value};

endmodule

// ----- src/ges_checker.sv -----
// ----------------------------------------------------------------------------
// ges_checker
// Port-level checks for the solver, attached to the top level by bind.
// ----------------------------------------------------------------------------
module ges_checker
	import ges_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tready,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [M_TDATA_W-1:0] m_axis_tdata,
	input logic                 m_axis_tlast,
	input logic                 m_axis_tuser
);

	// A singular report is always the final transfer of a run
	a_sing_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("singular result without last flag");

	// A singular report carries a zero value and index
	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("singular result with nonzero data");

	// No loading while results are pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input ready while result pending");

	// Stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

endmodule

bind gauss_elimination_solver ges_checker u_ges_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);
